### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/vma_pkg.sv
`timescale 1ns / 1ps

package vma_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 16;

   localparam logic [31:0] MASS_RESET = 32'd65536;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   // Four 32x32 partial products per multiply, one per step.
   localparam logic [2:0] MAC_LAST_STEP = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MULT,
      ST_STORE,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_W,
      OP_VSQ,
      OP_T1,
      OP_T2,
      OP_T3,
      OP_P,
      OP_O1,
      OP_O2,
      OP_O3
   } op_type;

   typedef struct packed {
      logic       capture;
      logic       load;
      logic       issue;
      logic       accum;
      logic [1:0] step;
      logic       store;
      logic       add_sums;
      logic       emit;
      op_type     op;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

### hw/rtl/vma_ctrl.sv
`timescale 1ns / 1ps

module vma_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  vma_pkg::status_type status,
   output vma_pkg::cmd_type    cmd
);

   vma_pkg::state_type state_ff, state_in;
   vma_pkg::op_type    op_ff, op_in;
   logic [2:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vma_pkg::ST_IDLE;
         op_ff        <= vma_pkg::OP_W;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.step     = step_ff[1:0];
      req_stall    = 1'b1;

      case (state_ff)
         vma_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = vma_pkg::OP_W;
               state_in    = vma_pkg::ST_LOAD;
            end
         end
         vma_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = vma_pkg::ST_MULT;
         end
         vma_pkg::ST_MULT: begin
            // The partial product issued in one step is added in the next.
            cmd.issue = (step_ff != vma_pkg::MAC_LAST_STEP);
            cmd.accum = (step_ff != 3'd0);
            step_in   = step_ff + 3'd1;
            if (step_ff == vma_pkg::MAC_LAST_STEP) begin
               state_in = vma_pkg::ST_STORE;
            end
         end
         vma_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = vma_pkg::ST_LOAD;
            case (op_ff)
               vma_pkg::OP_W:   op_in = vma_pkg::OP_VSQ;
               vma_pkg::OP_VSQ: op_in = vma_pkg::OP_T1;
               vma_pkg::OP_T1:  op_in = vma_pkg::OP_T2;
               vma_pkg::OP_T2:  op_in = vma_pkg::OP_T3;
               vma_pkg::OP_T3:  state_in = vma_pkg::ST_ADD;
               vma_pkg::OP_P:   op_in = vma_pkg::OP_O1;
               vma_pkg::OP_O1:  op_in = vma_pkg::OP_O2;
               vma_pkg::OP_O2:  op_in = vma_pkg::OP_O3;
               vma_pkg::OP_O3:  state_in = vma_pkg::ST_EMIT;
               default:         state_in = vma_pkg::ST_IDLE;
            endcase
         end
         vma_pkg::ST_ADD: begin
            cmd.add_sums = 1'b1;
            if (status.last) begin
               op_in    = vma_pkg::OP_P;
               state_in = vma_pkg::ST_LOAD;
            end else begin
               state_in = vma_pkg::ST_IDLE;
            end
         end
         vma_pkg::ST_EMIT: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = vma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vma_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/vma_datapath.sv
`timescale 1ns / 1ps

module vma_datapath #(
   parameter int unsigned FRAC_BITS = vma_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  vma_pkg::cmd_type    cmd,
   output vma_pkg::status_type status,
   input  logic                csr_write_en,
   input  logic [31:0]         csr_write_data,
   input  logic [31:0]         req_distribution_value,
   input  logic [31:0]         req_cell_volume,
   input  logic signed [31:0]  req_parallel_velocity,
   input  logic [31:0]         req_magnetic_moment,
   input  logic [31:0]         req_thermal_speed,
   input  logic [31:0]         req_thermal_speed_sq,
   input  logic                req_last_of_node,
   output logic signed [63:0]  rsp_density_moment,
   output logic signed [63:0]  rsp_momentum_moment,
   output logic signed [63:0]  rsp_perp_energy_moment,
   output logic signed [63:0]  rsp_para_energy_moment,
   output logic                rsp_saturated
);

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                           output logic sat);
      logic [63:0] r;
      r   = a + b;
      sat = (a[63] == b[63]) && (a[63] != r[63]);
      return sat ? (a[63] ? vma_pkg::SMIN : vma_pkg::SMAX) : r;
   endfunction

   function automatic logic [63:0] magnitude(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   logic [31:0]  mass_ff;
   logic [31:0]  f_ff, vol_ff, vmag_ff, mu_ff, vth_ff, vth2_ff;
   logic         vneg_ff, last_ff;
   logic [31:0]  vp_bits, vmag_in;

   logic [63:0]  w_ff, vsq_ff, t1_ff, t2_ff, t3_ff, p_ff;
   logic [63:0]  opa_ff, opb_ff, opa_in, opb_in;
   logic         neg_ff, neg_in, half_ff, half_in;
   logic [63:0]  pp_ff;
   logic [1:0]   pp_step_ff;
   logic [127:0] acc_ff, addend, shifted;
   logic [31:0]  a_half, b_half;

   logic [63:0]  sum_w_ff, sum_v_ff, sum_m_ff, sum_q_ff;
   logic         overflow_ff;
   logic [63:0]  sum_w_in, sum_v_in, sum_m_in, sum_q_in;
   logic         sat_w, sat_v, sat_m, sat_q;

   logic [63:0]  mag, result;
   logic         result_sat;

   logic [63:0]  rsp_dens_ff, rsp_mom_ff, rsp_perp_ff, rsp_para_ff;
   logic         rsp_sat_ff;

   assign vp_bits = req_parallel_velocity;
   assign vmag_in = vp_bits[31] ? (32'd0 - vp_bits) : vp_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= vma_pkg::MASS_RESET;
      end else if (csr_write_en) begin
         mass_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         f_ff    <= req_distribution_value;
         vol_ff  <= req_cell_volume;
         vmag_ff <= vmag_in;
         vneg_ff <= vp_bits[31];
         mu_ff   <= req_magnetic_moment;
         vth_ff  <= req_thermal_speed;
         vth2_ff <= req_thermal_speed_sq;
         last_ff <= req_last_of_node;
      end
   end

   assign status.last = last_ff;

   // Operand selection for the shared multiply unit.
   always_comb begin
      opa_in  = '0;
      opb_in  = '0;
      neg_in  = 1'b0;
      half_in = 1'b0;
      case (cmd.op)
         vma_pkg::OP_W: begin
            opa_in = {32'd0, f_ff};
            opb_in = {32'd0, vol_ff};
         end
         vma_pkg::OP_VSQ: begin
            opa_in = {32'd0, vmag_ff};
            opb_in = {32'd0, vmag_ff};
         end
         vma_pkg::OP_T1: begin
            opa_in = w_ff;
            opb_in = {32'd0, vmag_ff};
            neg_in = vneg_ff;
         end
         vma_pkg::OP_T2: begin
            opa_in = w_ff;
            opb_in = {32'd0, mu_ff};
         end
         vma_pkg::OP_T3: begin
            opa_in = w_ff;
            opb_in = vsq_ff;
         end
         vma_pkg::OP_P: begin
            opa_in = {32'd0, mass_ff};
            opb_in = {32'd0, vth2_ff};
         end
         vma_pkg::OP_O1: begin
            opa_in = magnitude(sum_v_ff);
            opb_in = {32'd0, vth_ff};
            neg_in = sum_v_ff[63];
         end
         vma_pkg::OP_O2: begin
            opa_in  = magnitude(sum_m_ff);
            opb_in  = p_ff;
            neg_in  = sum_m_ff[63];
            half_in = 1'b1;
         end
         vma_pkg::OP_O3: begin
            opa_in = magnitude(sum_q_ff);
            opb_in = p_ff;
            neg_in = sum_q_ff[63];
         end
         default: begin
            opa_in = '0;
         end
      endcase
   end

   // Step k multiplies half k[1] of A by half k[0] of B.
   assign a_half = cmd.step[1] ? opa_ff[63:32] : opa_ff[31:0];
   assign b_half = cmd.step[0] ? opb_ff[63:32] : opb_ff[31:0];

   always_comb begin
      case (pp_step_ff)
         2'd0:    addend = {64'd0, pp_ff};
         2'd3:    addend = {pp_ff, 64'd0};
         default: addend = {32'd0, pp_ff, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opa_ff  <= opa_in;
         opb_ff  <= opb_in;
         neg_ff  <= neg_in;
         half_ff <= half_in;
         acc_ff  <= '0;
      end else if (cmd.accum) begin
         acc_ff <= acc_ff + addend;
      end
      if (cmd.issue) begin
         pp_ff      <= a_half * b_half;
         pp_step_ff <= cmd.step;
      end
   end

   // Truncate the product, apply the sign and clamp to the signed range.
   assign shifted = half_ff ? (acc_ff >> (FRAC_BITS + 1)) : (acc_ff >> FRAC_BITS);
   assign mag     = shifted[63:0];

   always_comb begin
      result_sat = 1'b0;
      if (|shifted[127:64]) begin
         result_sat = 1'b1;
         result     = neg_ff ? vma_pkg::SMIN : vma_pkg::SMAX;
      end else if (!neg_ff) begin
         result_sat = mag[63];
         result     = mag[63] ? vma_pkg::SMAX : mag;
      end else begin
         result_sat = (mag > vma_pkg::SMIN);
         result     = result_sat ? vma_pkg::SMIN : (64'd0 - mag);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.op)
            vma_pkg::OP_W:   w_ff   <= result;
            vma_pkg::OP_VSQ: vsq_ff <= result;
            vma_pkg::OP_T1:  t1_ff  <= result;
            vma_pkg::OP_T2:  t2_ff  <= result;
            vma_pkg::OP_T3:  t3_ff  <= result;
            vma_pkg::OP_P:   p_ff   <= result;
            vma_pkg::OP_O1:  t1_ff  <= result;
            vma_pkg::OP_O2:  t2_ff  <= result;
            vma_pkg::OP_O3:  t3_ff  <= result;
            default:         p_ff   <= result;
         endcase
      end
   end

   always_comb begin
      sum_w_in = sat_add(sum_w_ff, w_ff, sat_w);
      sum_v_in = sat_add(sum_v_ff, t1_ff, sat_v);
      sum_m_in = sat_add(sum_m_ff, t2_ff, sat_m);
      sum_q_in = sat_add(sum_q_ff, t3_ff, sat_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_w_ff    <= '0;
         sum_v_ff    <= '0;
         sum_m_ff    <= '0;
         sum_q_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.emit) begin
         sum_w_ff    <= '0;
         sum_v_ff    <= '0;
         sum_m_ff    <= '0;
         sum_q_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.add_sums) begin
         sum_w_ff    <= sum_w_in;
         sum_v_ff    <= sum_v_in;
         sum_m_ff    <= sum_m_in;
         sum_q_ff    <= sum_q_in;
         overflow_ff <= overflow_ff | sat_w | sat_v | sat_m | sat_q;
      end else if (cmd.store) begin
         // Each stored product reports into the same per-node flag.
         overflow_ff <= overflow_ff | result_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_dens_ff <= sum_w_ff;
         rsp_mom_ff  <= t1_ff;
         rsp_perp_ff <= t2_ff;
         rsp_para_ff <= t3_ff;
         rsp_sat_ff  <= overflow_ff;
      end
   end

   assign rsp_density_moment     = rsp_dens_ff;
   assign rsp_momentum_moment    = rsp_mom_ff;
   assign rsp_perp_energy_moment = rsp_perp_ff;
   assign rsp_para_energy_moment = rsp_para_ff;
   assign rsp_saturated          = rsp_sat_ff;

endmodule

### hw/rtl/velocity_moment_accumulator_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_stall  one velocity-grid sample and last flag
// rsp_      out        rsp_valid/rsp_stall  four node moments and saturation flag
// csr_      in         csr_write_en         particle mass
//
// Each sample runs through the single shared 32x32 multiplier, which computes
// five products per sample (four more on the last of a node), each as four
// partial products; the last sample of a node may also wait for the output
// register. Reset clears the sums and sets the particle mass to 1.0. A result
// waiting under rsp_stall holds; the next sample is still taken and stops only
// when its own result needs the register.

module velocity_moment_accumulator_top #(
   parameter int unsigned FRAC_BITS = vma_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_distribution_value,
   input  logic [31:0]        req_cell_volume,
   input  logic signed [31:0] req_parallel_velocity,
   input  logic [31:0]        req_magnetic_moment,
   input  logic [31:0]        req_thermal_speed,
   input  logic [31:0]        req_thermal_speed_sq,
   input  logic               req_last_of_node,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_density_moment,
   output logic signed [63:0] rsp_momentum_moment,
   output logic signed [63:0] rsp_perp_energy_moment,
   output logic signed [63:0] rsp_para_energy_moment,
   output logic               rsp_saturated,
   input  logic               csr_write_en,
   input  logic [31:0]        csr_write_data
);

   vma_pkg::cmd_type    cmd;
   vma_pkg::status_type status;

   vma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vma_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write_en           (csr_write_en),
      .csr_write_data         (csr_write_data),
      .req_distribution_value (req_distribution_value),
      .req_cell_volume        (req_cell_volume),
      .req_parallel_velocity  (req_parallel_velocity),
      .req_magnetic_moment    (req_magnetic_moment),
      .req_thermal_speed      (req_thermal_speed),
      .req_thermal_speed_sq   (req_thermal_speed_sq),
      .req_last_of_node       (req_last_of_node),
      .rsp_density_moment     (rsp_density_moment),
      .rsp_momentum_moment    (rsp_momentum_moment),
      .rsp_perp_energy_moment (rsp_perp_energy_moment),
      .rsp_para_energy_moment (rsp_para_energy_moment),
      .rsp_saturated          (rsp_saturated)
   );

endmodule

### hw/rtl/vma_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vma_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [63:0] rsp_density_moment,
   input logic               rsp_saturated
);

   // A stalled result stays on the port unchanged.
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_density_moment))
   `ASSERT_NEXT(a_rsp_flag_hold, rsp_valid && rsp_stall, $stable(rsp_saturated))

   // Each sample occupies the multiplier, so input stalls once a sample is taken.
   `ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall)

   // While the block is ready for input no new result is being loaded, so a
   // result taken in that cycle leaves the output empty.
   `ASSERT_NEXT(a_rsp_drains_when_idle, rsp_valid && !rsp_stall && !req_stall, !rsp_valid)

endmodule

bind velocity_moment_accumulator_top vma_checker u_vma_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_density_moment (rsp_density_moment),
   .rsp_saturated      (rsp_saturated)
);
